/* hdl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");

`endif

/* hdl/flbc_pkg.sv */
// types, codes and progress table for the four led blink controller
package flbc_pkg;

	localparam int unsigned NUM_LEDS = 4;
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
	localparam logic [15:0] PERIOD_RESET = 16'd500;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SET_ALL  = 2'd1,
		ACT_SET_ONE  = 2'd2,
		ACT_PROGRESS = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_OFF        = 2'd0,
		MODE_ON         = 2'd1,
		MODE_BLINK_LIT  = 2'd2,
		MODE_BLINK_DARK = 2'd3
	} mode_t;

	typedef logic [NUM_LEDS-1:0][1:0] mode_vec_t;

	typedef struct packed {
		action_t           action;
		logic [7:0]        all_modes;
		logic [1:0]        led_index;
		logic [1:0]        led_mode;
		logic signed [7:0] percent;
	} item_t;

	// progress bar: upper leds fill first, the next one blinks
	function automatic mode_vec_t progress_modes(input logic signed [7:0] pct);
		mode_vec_t m;
		m = {NUM_LEDS{MODE_OFF}};
		if (pct < 8'sd0) begin
			m = {NUM_LEDS{MODE_OFF}};
		end else if (pct < 8'sd25) begin
			m[3] = MODE_BLINK_LIT;
		end else if (pct < 8'sd50) begin
			m[3] = MODE_ON;
			m[2] = MODE_BLINK_LIT;
		end else if (pct < 8'sd75) begin
			m[3] = MODE_ON;
			m[2] = MODE_ON;
			m[1] = MODE_BLINK_LIT;
		end else if (pct < 8'sd100) begin
			m[3] = MODE_ON;
			m[2] = MODE_ON;
			m[1] = MODE_ON;
			m[0] = MODE_BLINK_LIT;
		end else begin
			m = {NUM_LEDS{MODE_ON}};
		end
		return m;
	endfunction

endpackage

/* hdl/four_led_blink_controller.sv */
// top level of the four led blink controller
// usage:
//   s_* takes one command word per cycle unless stalled; tuser carries the action
//   (tick, set all modes, set one mode, progress), tdata the operand fields.
//   every accepted word yields exactly one result word on m_*, whose tdata
//   holds the four led levels driven after the last tick.
//   cfg_* writes blink_period_ms; write only while no word is in flight.
// timing:
//   a word passes the input register, the state update and then the result
//   register. throughput is one word per cycle while m_tready stays high.
// reset:
//   arst_n clears all modes to off, levels low, the elapsed counter to zero
//   and sets the period to 500 ticks; no words are held.
// stall:
//   a stalled m_tready holds the result; the input register still takes one
//   more word, then s_tready drops until the result is taken.
`include "assert_macros.svh"

module four_led_blink_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // all_modes, led_index, led_mode, percent, zero pad
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // led_pattern, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic            valid_s1;
	flbc_pkg::item_t item_s1;
	logic            fire;
	logic [3:0]      pattern;
	logic            out_valid_q;
	logic [3:0]      out_pattern_q;

	assign fire      = valid_s1 && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;

	flbc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	flbc_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.step      (fire),
		.item      (item_s1),
		.pattern   (pattern)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_pattern_q <= pattern;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_pattern_q};

	`ASSERT_IMPL(a_ready_only_full, clk, arst_n, !s_tready, valid_s1 && out_valid_q && !m_tready)
	`ASSERT_NEXT(a_fire_gives_word, clk, arst_n, fire, out_valid_q)

endmodule

/* hdl/flbc_in_stage.sv */
// input register stage: captures one word and holds it until consumed
module flbc_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,   // all_modes, led_index, led_mode, percent, zero pad
	input  logic [1:0]         s_tuser,   // action
	input  logic               take,
	output logic               valid_s1,
	output flbc_pkg::item_t    item_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.action    <= flbc_pkg::action_t'(s_tuser);
			item_s1.all_modes <= s_tdata[7:0];
			item_s1.led_index <= s_tdata[9:8];
			item_s1.led_mode  <= s_tdata[11:10];
			item_s1.percent   <= s_tdata[19:12];
		end
	end

endmodule

/* hdl/flbc_state.sv */
// led modes, levels, elapsed counter and period register with their update logic
`include "assert_macros.svh"

module flbc_state (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	input  logic [15:0]     cfg_data,
	input  logic            step,
	input  flbc_pkg::item_t item,
	output logic [3:0]      pattern
);

	logic [15:0]               period_q;
	flbc_pkg::mode_vec_t       mode_q;
	flbc_pkg::mode_vec_t       seen_q;
	logic [3:0]                level_q;
	logic [15:0]               elapsed_q;
	logic [3:0]                driven_q;

	flbc_pkg::mode_vec_t       mode_d;
	logic [3:0]                level_d;
	logic [3:0]                blink;
	logic [3:0]                lit;
	logic [15:0]               elapsed_inc;
	logic                      changed;
	logic                      toggle;
	logic                      is_tick;

	assign is_tick = (item.action == flbc_pkg::ACT_TICK);

	always_comb begin
		mode_d = mode_q;
		case (item.action)
			flbc_pkg::ACT_SET_ALL:  mode_d = item.all_modes;
			flbc_pkg::ACT_SET_ONE:  mode_d[item.led_index] = item.led_mode;
			flbc_pkg::ACT_PROGRESS: mode_d = flbc_pkg::progress_modes(item.percent);
			default:                mode_d = mode_q;
		endcase
	end

	// tick: count, refresh levels on mode change, then blink compare
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			blink[i] = mode_q[i][1];
			lit[i]   = (mode_q[i] == flbc_pkg::MODE_ON) ||
			           (mode_q[i] == flbc_pkg::MODE_BLINK_LIT);
		end
		elapsed_inc = (elapsed_q == flbc_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 16'd1;
		changed     = (mode_q != seen_q);
		toggle      = (|blink) && (elapsed_inc >= period_q);
		level_d     = (changed ? lit : level_q) ^ (toggle ? blink : 4'b0000);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= flbc_pkg::PERIOD_RESET;
			mode_q    <= {4{flbc_pkg::MODE_OFF}};
			seen_q    <= {4{flbc_pkg::MODE_OFF}};
			level_q   <= 4'b0000;
			elapsed_q <= 16'd0;
			driven_q  <= 4'b0000;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (step) begin
				mode_q <= mode_d;
				if (is_tick) begin
					seen_q    <= mode_q;
					level_q   <= level_d;
					elapsed_q <= toggle ? 16'd0 : elapsed_inc;
					driven_q  <= level_d;
				end
			end
		end
	end

	assign pattern = (step && is_tick) ? level_d : driven_q;

	`ASSERT_NEXT(a_toggle_restarts, clk, arst_n, step && is_tick && toggle, elapsed_q == 16'd0)
	`ASSERT_NEXT(a_cmd_keeps_driven, clk, arst_n, step && !is_tick, $stable(driven_q))
	`ASSERT_NEXT(a_tick_syncs_seen, clk, arst_n, step && is_tick, seen_q == $past(mode_q))

endmodule

/* bench/four_led_blink_controller_chk.sv */
// checker for the four led blink controller: predicts led_pattern and compares results
module four_led_blink_controller_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // all_modes, led_index, led_mode, percent, zero pad
	input  logic [1:0]  s_tuser,   // action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // led_pattern, zero pad
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          fails,
	output int          pending,
	output int          checked,
	output int          toggles
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [15:0]                   period_ms;
	flbc_pkg::mode_t               cur_mode [flbc_pkg::NUM_LEDS];
	flbc_pkg::mode_t               seen_mode [flbc_pkg::NUM_LEDS];
	logic [flbc_pkg::NUM_LEDS-1:0] lvl;
	logic [15:0]                   elapsed_ms;
	logic [3:0]                    shown;
	logic [3:0]                    pattern_q [$];
	logic [3:0]                    want;

	function automatic logic blinks(flbc_pkg::mode_t m);
		return m == flbc_pkg::MODE_BLINK_LIT || m == flbc_pkg::MODE_BLINK_DARK;
	endfunction

	// one millisecond: count, pick up new modes, then the blink compare
	task automatic tick_ms();
		logic changed;
		logic any_blink;
		changed = 1'b0;
		any_blink = 1'b0;
		if (elapsed_ms != flbc_pkg::ELAPSED_MAX)
			elapsed_ms++;
		for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
			if (cur_mode[i] != seen_mode[i])
				changed = 1'b1;
		if (changed) begin
			for (int i = 0; i < flbc_pkg::NUM_LEDS; i++) begin
				seen_mode[i] = cur_mode[i];
				lvl[i] = (cur_mode[i] == flbc_pkg::MODE_ON ||
					cur_mode[i] == flbc_pkg::MODE_BLINK_LIT);
			end
		end
		for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
			if (blinks(cur_mode[i]))
				any_blink = 1'b1;
		if (any_blink && elapsed_ms >= period_ms) begin
			elapsed_ms = '0;
			toggles++;
			for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
				if (blinks(cur_mode[i]))
					lvl[i] = ~lvl[i];
		end
		shown = lvl;
	endtask

	// bar fills from led 3 down, one quarter per led, the next led blinks lit
	task automatic set_progress(logic signed [7:0] pct);
		int quarters;
		for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
			cur_mode[i] = flbc_pkg::MODE_OFF;
		if (pct >= 100) begin
			for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
				cur_mode[i] = flbc_pkg::MODE_ON;
		end else if (pct >= 0) begin
			quarters = int'(pct) / 25;
			for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
				if (i > 3 - quarters)
					cur_mode[i] = flbc_pkg::MODE_ON;
			cur_mode[3 - quarters] = flbc_pkg::MODE_BLINK_LIT;
		end
	endtask

	task automatic take_word(flbc_pkg::action_t act, logic [23:0] d);
		case (act)
			flbc_pkg::ACT_TICK: begin
				tick_ms();
			end
			flbc_pkg::ACT_SET_ALL: begin
				for (int i = 0; i < flbc_pkg::NUM_LEDS; i++)
					cur_mode[i] = flbc_pkg::mode_t'(d[2*i +: 2]);
			end
			flbc_pkg::ACT_SET_ONE: begin
				cur_mode[d[9:8]] = flbc_pkg::mode_t'(d[11:10]);
			end
			default: begin
				set_progress($signed(d[19:12]));
			end
		endcase
		pattern_q.push_back(shown);
	endtask

	task automatic log_miss(string what, logic [3:0] want_v, logic [3:0] got_v);
		if (fails < 10)
			$display("%0t led_pattern %s: expected %h, got %h", $realtime, what, want_v, got_v);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_ms = flbc_pkg::PERIOD_RESET;
			for (int i = 0; i < flbc_pkg::NUM_LEDS; i++) begin
				cur_mode[i] = flbc_pkg::MODE_OFF;
				seen_mode[i] = flbc_pkg::MODE_OFF;
			end
			lvl = '0;
			elapsed_ms = '0;
			shown = '0;
			pattern_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
			toggles = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pattern_q.size() == 0) begin
					log_miss("word with none pending", 4'bx, m_tdata[3:0]);
				end else begin
					want = pattern_q.pop_front();
					checked++;
					if (m_tdata[3:0] !== want)
						log_miss("mismatch", want, m_tdata[3:0]);
				end
			end
			if (cfg_valid && cfg_ready)
				period_ms = cfg_data;
			if (s_tvalid && s_tready)
				take_word(flbc_pkg::action_t'(s_tuser), s_tdata);
			pending = pattern_q.size();
		end
	end

endmodule

/* bench/four_led_blink_controller_tb.sv */
// stimulus and verdict for the four led blink controller
module four_led_blink_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // all_modes, led_index, led_mode, percent, zero pad
	logic [1:0]  s_tuser;   // action
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // led_pattern, zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	int fails;
	int pending;
	int checked;
	int toggles;
	int words_sent;
	int rx_stall;
	int hold_reqs;
	int holds_done;
	bit idle_en;

	logic signed [7:0] bar_pts [10] = '{8'sh80, 8'sd0, 8'sd24, 8'sd25, 8'sd50, 8'sd74,
		8'sd75, 8'sd99, 8'sd100, 8'sd127};
	logic signed [7:0] pct_edges [12] = '{8'sh80, 8'shFF, 8'sd0, 8'sd24, 8'sd25, 8'sd49,
		8'sd50, 8'sd74, 8'sd75, 8'sd99, 8'sd100, 8'sd127};
	logic [15:0]       phase_period [6] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd7, 16'd1};

	four_led_blink_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	four_led_blink_controller_chk chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked),
		.toggles   (toggles)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("four_led_blink_controller: mismatch");
		$finish;
	end

	function automatic logic [23:0] pack_word(logic [7:0] all, logic [1:0] idx,
			logic [1:0] md, logic signed [7:0] pct);
		return {4'h0, pct, md, idx, all};
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic put_word(flbc_pkg::action_t act, logic [23:0] d);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = act;
		s_tdata = d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic put_tick();
		put_word(flbc_pkg::ACT_TICK, 24'($urandom) & 24'h0F_FFFF);
	endtask

	task automatic put_random();
		int r;
		logic signed [7:0] pct;
		flbc_pkg::action_t act;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 1))
			pct = pct_edges[$urandom_range(0, 11)];
		else
			pct = 8'($urandom);
		if (r < 55)
			act = flbc_pkg::ACT_TICK;
		else if (r < 70)
			act = flbc_pkg::ACT_SET_ALL;
		else if (r < 85)
			act = flbc_pkg::ACT_SET_ONE;
		else
			act = flbc_pkg::ACT_PROGRESS;
		put_word(act, pack_word(8'($urandom), 2'($urandom), 2'($urandom), pct));
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_period(logic [15:0] v);
		drain();
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// result side: random stall bursts, plus one long hold on request
	initial begin
		m_tready = 1'b0;
		rx_stall = 0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_done < hold_reqs) begin
				m_tready = 1'b0;
				repeat (200) @(negedge clk);
				holds_done++;
			end else if (rx_stall > 0) begin
				m_tready = 1'b0;
				rx_stall--;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				m_tready = 1'b0;
				rx_stall = $urandom_range(1, 19) - 1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = flbc_pkg::ACT_TICK;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_en = 1'b0;
		hold_reqs = 0;
		words_sent = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset period
		put_tick();
		put_word(flbc_pkg::ACT_SET_ALL, pack_word(8'b11_10_01_00, 2'd0, flbc_pkg::MODE_OFF, 8'sd0));
		put_tick();
		put_word(flbc_pkg::ACT_SET_ONE, pack_word(8'h00, 2'd3, flbc_pkg::MODE_ON, 8'sd0));
		put_word(flbc_pkg::ACT_SET_ONE,
			pack_word(8'hFF, 2'd0, flbc_pkg::MODE_BLINK_DARK, 8'sd127));
		put_tick();
		foreach (bar_pts[k]) begin
			put_word(flbc_pkg::ACT_PROGRESS,
				pack_word(8'h00, 2'd0, flbc_pkg::MODE_OFF, bar_pts[k]));
			put_tick();
		end

		// default period toggles, long result hold while words keep coming
		put_word(flbc_pkg::ACT_SET_ALL, pack_word(8'hAA, 2'd0, flbc_pkg::MODE_OFF, 8'sd0));
		hold_reqs++;
		repeat (520) put_tick();

		// nothing blinks: the elapsed count keeps running without toggles
		put_word(flbc_pkg::ACT_SET_ALL, pack_word(8'h00, 2'd0, flbc_pkg::MODE_OFF, 8'sd0));
		repeat (20) put_tick();
		write_period(16'hFFFF);
		put_word(flbc_pkg::ACT_SET_ALL, pack_word(8'hFF, 2'd0, flbc_pkg::MODE_OFF, 8'sd0));
		repeat (3) put_tick();

		// zero period toggles on every tick
		write_period(16'd0);
		put_word(flbc_pkg::ACT_SET_ONE,
			pack_word(8'h00, 2'd1, flbc_pkg::MODE_BLINK_LIT, 8'sd0));
		repeat (6) put_tick();

		phase_period[4] = 16'($urandom_range(4, 12));
		for (int ph = 0; ph < 6; ph++) begin
			write_period(phase_period[ph]);
			idle_en = (ph < 5);
			if (ph == 2)
				hold_reqs++;
			repeat (200) put_random();
		end

		drain();
		repeat (10) @(negedge clk);
		$display("sent %0d command words with blink periods from 0 to 65535 and all bar bands",
			words_sent);
		$display("checked %0d results, %0d blink toggles, with stalls on both sides",
			checked, toggles);
		if (fails == 0 && pending == 0)
			$display("four_led_blink_controller: match");
		else
			$display("four_led_blink_controller: mismatch");
		$finish;
	end

endmodule
